/* src/bhe_pkg.sv */
// ----------------------------------------------------------------------------
// bhe_pkg
// Shared constants, lookup tables, interpolation and control types for the
// battery health estimator.
// ----------------------------------------------------------------------------
package bhe_pkg;

   localparam int WINDOW_LEN_DEFAULT = 8;
   localparam int DIV_W = 40;

   localparam logic [16:0] NOMINAL_RESET = 17'd65536;
   localparam logic [16:0] TEMP_OFFSET   = 17'd6400;
   localparam logic [15:0] TEMP_COEF16   = 16'd26208;
   localparam logic [13:0] RATE_COEF     = 14'd6554;
   localparam logic [22:0] DIV3_RECIP    = 23'd5592406;
   localparam logic [23:0] STEP_COEF     = 24'd12884902;
   localparam logic [25:0] REGEN_COEF    = 26'd64424509;
   localparam logic [22:0] VOLT_OFFSET   = 23'd943718;
   localparam logic [32:0] FLAT_LIMIT    = 33'd167;
   localparam logic [39:0] RATE_MIN      = 40'd4295;
   localparam logic [32:0] BUDGET        = 33'd5033165;
   localparam logic [39:0] LIFE_MAX      = 40'd4800000;

   // table selects
   localparam logic [1:0] TAB_EXP = 2'd0;
   localparam logic [1:0] TAB_SPL = 2'd1;
   localparam logic [1:0] TAB_SIG = 2'd2;

   // datapath operations
   localparam logic [4:0] OP_NONE     = 5'd0;
   localparam logic [4:0] OP_LOAD     = 5'd1;
   localparam logic [4:0] OP_STRESS   = 5'd2;
   localparam logic [4:0] OP_UDIV     = 5'd3;
   localparam logic [4:0] OP_SPL      = 5'd4;
   localparam logic [4:0] OP_STEP     = 5'd5;
   localparam logic [4:0] OP_DMG      = 5'd6;
   localparam logic [4:0] OP_EXP      = 5'd7;
   localparam logic [4:0] OP_AB       = 5'd8;
   localparam logic [4:0] OP_RG1      = 5'd9;
   localparam logic [4:0] OP_RG2      = 5'd10;
   localparam logic [4:0] OP_SOC      = 5'd11;
   localparam logic [4:0] OP_HEALTH   = 5'd12;
   localparam logic [4:0] OP_RATE     = 5'd13;
   localparam logic [4:0] OP_RATE_FIN = 5'd14;
   localparam logic [4:0] OP_LIFE     = 5'd15;
   localparam logic [4:0] OP_LIFE_FIN = 5'd16;
   localparam logic [4:0] OP_OUT      = 5'd17;

   typedef struct packed {
      logic [4:0] op;
   } cmd_type;

   typedef struct packed {
      logic dw_big;
      logic budget_pos;
      logic div_done;
   } status_type;

   function automatic logic [16:0] exp_entry(input logic [4:0] idx);
      logic [16:0] v;
      unique case (idx)
         5'd0: v = 17'd65536;  5'd1: v = 17'd39750;  5'd2: v = 17'd24109;
         5'd3: v = 17'd14623;  5'd4: v = 17'd8869;   5'd5: v = 17'd5380;
         5'd6: v = 17'd3263;   5'd7: v = 17'd1979;   5'd8: v = 17'd1200;
         5'd9: v = 17'd728;    5'd10: v = 17'd442;   5'd11: v = 17'd268;
         5'd12: v = 17'd162;   5'd13: v = 17'd99;    5'd14: v = 17'd60;
         5'd15: v = 17'd36;    5'd16: v = 17'd22;
         default: v = 17'd22;
      endcase
      return v;
   endfunction

   function automatic logic [16:0] spl_entry(input logic [4:0] idx);
      logic [16:0] v;
      unique case (idx)
         5'd0: v = 17'd45426;  5'd1: v = 17'd31069;  5'd2: v = 17'd20530;
         5'd3: v = 17'd13200;  5'd4: v = 17'd8318;   5'd5: v = 17'd5170;
         5'd6: v = 17'd3184;   5'd7: v = 17'd1950;   5'd8: v = 17'd1189;
         5'd9: v = 17'd724;    5'd10: v = 17'd440;   5'd11: v = 17'd267;
         5'd12: v = 17'd162;   5'd13: v = 17'd98;    5'd14: v = 17'd60;
         5'd15: v = 17'd36;    5'd16: v = 17'd22;
         default: v = 17'd22;
      endcase
      return v;
   endfunction

   function automatic logic [16:0] sig_entry(input logic [4:0] idx);
      logic [16:0] v;
      unique case (idx)
         5'd0: v = 17'd32768;  5'd1: v = 17'd40793;  5'd2: v = 17'd47911;
         5'd3: v = 17'd53581;  5'd4: v = 17'd57724;  5'd5: v = 17'd60565;
         5'd6: v = 17'd62428;  5'd7: v = 17'd63615;  5'd8: v = 17'd64357;
         5'd9: v = 17'd64816;  5'd10: v = 17'd65097; 5'd11: v = 17'd65269;
         5'd12: v = 17'd65374; 5'd13: v = 17'd65438; 5'd14: v = 17'd65476;
         5'd15: v = 17'd65500; 5'd16: v = 17'd65514;
         default: v = 17'd65514;
      endcase
      return v;
   endfunction

   function automatic logic [16:0] tab_entry(input logic [1:0] sel, input logic [4:0] idx);
      logic [16:0] v;
      unique case (sel)
         TAB_EXP: v = exp_entry(idx);
         TAB_SPL: v = spl_entry(idx);
         default: v = sig_entry(idx);
      endcase
      return v;
   endfunction

   // Linear interpolation over 17 points spaced 0.5 apart, Q16 argument.
   function automatic logic [16:0] interp(input logic [1:0] sel, input logic [21:0] y);
      logic [6:0]         i;
      logic [14:0]        f;
      logic [16:0]        a;
      logic [16:0]        b;
      logic signed [17:0] d;
      logic signed [33:0] prod;
      logic signed [33:0] sum;
      i = y[21:15];
      f = y[14:0];
      a = tab_entry(sel, i[4:0]);
      b = tab_entry(sel, i[4:0] + 5'd1);
      d = signed'({1'b0, b}) - signed'({1'b0, a});
      prod = d * signed'({1'b0, f});
      sum = signed'({17'd0, a}) + ((prod + 34'sd16384) >>> 15);
      if (i >= 7'd16) begin
         return tab_entry(sel, 5'd16);
      end
      return sum[16:0];
   endfunction

endpackage

/* src/bhe_div.sv */
// ----------------------------------------------------------------------------
// bhe_div
// Restoring divider, one quotient bit per cycle; pulses done when finished.
// ----------------------------------------------------------------------------
module bhe_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bhe_pkg::DIV_W-1:0]  dividend,
   input  logic [bhe_pkg::DIV_W-1:0]  divisor,
   output logic                       done,
   output logic [bhe_pkg::DIV_W-1:0]  quotient
);
   import bhe_pkg::*;

   localparam int CW = $clog2(DIV_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DIV_W:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]  den_ff, den_in;
   logic [DIV_W:0]    shifted;

   // shift in one dividend bit, subtract where it fits
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      shifted = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = shifted - {1'b0, den_ff};
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* src/bhe_datapath.sv */
// ----------------------------------------------------------------------------
// bhe_datapath
// Operand registers, arithmetic steps, damage window and output registers.
// ----------------------------------------------------------------------------
module bhe_datapath #(
   parameter int WINDOW_LEN = bhe_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  bhe_pkg::cmd_type    cmd,
   output bhe_pkg::status_type status,
   input  logic                csr_write_enable,
   input  logic [16:0]         csr_write_data,
   input  logic signed [15:0]  req_temperature,
   input  logic signed [15:0]  req_charge_rate,
   input  logic [15:0]         req_rest_duration,
   input  logic [15:0]         req_rest_onset_charge,
   input  logic                req_rest_enable,
   input  logic [15:0]         req_mean_voltage,
   output logic signed [17:0]  rsp_health,
   output logic [15:0]         rsp_charge_level,
   output logic [22:0]         rsp_remaining_life,
   output logic [31:0]         rsp_damage_total,
   output logic [17:0]         rsp_regeneration,
   output logic [23:0]         rsp_damage_step
);
   import bhe_pkg::*;

   localparam logic [DIV_W-1:0] WIN_DIV = DIV_W'(WINDOW_LEN);

   // configuration
   logic [16:0] nominal_ff;
   logic [16:0] nom;

   // captured transaction
   logic signed [15:0] temp_ff;
   logic signed [15:0] crate_ff;
   logic [15:0]        rest_ff, onset_ff, volt_ff;
   logic               flag_ff;

   // intermediates
   logic [21:0]        mag_ff, mag_in;
   logic               spos_ff, spos_in;
   logic [21:0]        u_ff;
   logic [19:0]        sp_ff;
   logic [23:0]        step_ff;
   logic [31:0]        dmg_ff, acc_ff;
   logic signed [32:0] dw_ff;
   logic [16:0]        e_ff;
   logic [33:0]        p_ff;
   logic [42:0]        rhi_ff;
   logic [17:0]        regen_ff;
   logic [15:0]        soc_ff;
   logic signed [17:0] health_ff;
   logic [DIV_W-1:0]   rate_ff;
   logic [22:0]        life_ff;
   logic [31:0]        win_ff [WINDOW_LEN];

   // output registers
   logic signed [17:0] o_health_ff;
   logic [15:0]        o_soc_ff;
   logic [22:0]        o_life_ff;
   logic [31:0]        o_dmg_ff;
   logic [17:0]        o_regen_ff;
   logic [23:0]        o_step_ff;

   // combinational terms
   logic signed [16:0] t_off;
   logic signed [32:0] s_temp, s_rate, s28, s_abs;
   logic [44:0]        u_prod;
   logic [43:0]        step_prod;
   logic [24:0]        step_rnd;
   logic [32:0]        dmg_sum;
   logic [42:0]        rlo;
   logic [59:0]        rtot;
   logic signed [34:0] soh;
   logic signed [25:0] soh_c;
   logic signed [22:0] vx;
   logic [21:0]        vabs;
   logic [16:0]        hsig;
   logic [32:0]        budget;
   logic [DIV_W-1:0]   rate_raw;
   logic               div_start;
   logic [DIV_W-1:0]   div_num, div_den, quo;
   logic               div_done;

   assign nom = (nominal_ff == 17'd0) ? NOMINAL_RESET : nominal_ff;

   // stress projection, exp argument, rounding and sums
   always_comb begin
      t_off     = signed'({temp_ff[15], temp_ff}) - signed'(TEMP_OFFSET);
      s_temp    = 33'(t_off * signed'({1'b0, TEMP_COEF16}));
      s_rate    = 33'(crate_ff * signed'({1'b0, RATE_COEF}));
      s28       = s_temp + s_rate;
      s_abs     = s28[32] ? -s28 : s28;
      mag_in    = 22'(s_abs[32:12]);
      spos_in   = !s28[32] && (s28 != 33'sd0);
      u_prod    = {rest_ff, 6'd0} * DIV3_RECIP;
      step_prod = sp_ff * STEP_COEF;
      step_rnd  = 25'((step_prod + 44'd8388608) >> 24);
      dmg_sum   = {1'b0, acc_ff} + {9'd0, step_ff};
      rlo       = p_ff[16:0] * REGEN_COEF;
      rtot      = {rhi_ff, 17'd0} + {17'd0, rlo} + (60'd1 << 40);
      soh       = signed'({10'd0, nom, 8'd0}) - signed'({3'd0, dmg_ff})
                  + signed'({17'd0, regen_ff});
      if (soh < -35'sd33554432) begin
         soh_c = -26'sd33554432;
      end else if (soh > 35'sd33554431) begin
         soh_c = 26'sd33554431;
      end else begin
         soh_c = soh[25:0];
      end
      vx        = signed'({1'b0, volt_ff, 6'd0}) - signed'(VOLT_OFFSET);
      vabs      = vx[22] ? 22'(-vx) : 22'(vx);
      hsig      = interp(TAB_SIG, vabs);
      budget    = BUDGET - {1'b0, dmg_ff};
      rate_raw  = rate_ff;
   end

   // shared divider: window rate, then remaining life
   always_comb begin
      div_start = 1'b0;
      div_num   = {7'd0, dw_ff[32:0]} << 8;
      div_den   = WIN_DIV;
      if (cmd.op == OP_RATE && status.dw_big) begin
         div_start = 1'b1;
      end else if (cmd.op == OP_LIFE && status.budget_pos) begin
         div_start = 1'b1;
         div_num   = {budget[27:0], 12'd0};
         div_den   = rate_raw;
      end
   end

   bhe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (quo)
   );

   assign status.dw_big     = dw_ff > signed'(FLAT_LIMIT);
   assign status.budget_pos = !budget[32] && (budget != 33'd0);
   assign status.div_done   = div_done;

   // configuration, accumulated damage and window
   always_ff @(posedge clock) begin
      if (reset) begin
         nominal_ff <= NOMINAL_RESET;
         acc_ff     <= '0;
         for (int k = 0; k < WINDOW_LEN; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            nominal_ff <= csr_write_data;
         end
         if (cmd.op == OP_DMG) begin
            acc_ff <= dmg_sum[32] ? 32'hFFFF_FFFF : dmg_sum[31:0];
            for (int k = 0; k < WINDOW_LEN - 1; k++) begin
               win_ff[k] <= win_ff[k + 1];
            end
            win_ff[WINDOW_LEN - 1] <= dmg_sum[32] ? 32'hFFFF_FFFF : dmg_sum[31:0];
         end
      end
   end

   // step through the operations
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            temp_ff  <= req_temperature;
            crate_ff <= req_charge_rate;
            rest_ff  <= req_rest_duration;
            onset_ff <= req_rest_onset_charge;
            flag_ff  <= req_rest_enable;
            volt_ff  <= req_mean_voltage;
         end
         OP_STRESS: begin
            mag_ff  <= mag_in;
            spos_ff <= spos_in;
         end
         OP_UDIV: u_ff <= {1'b0, u_prod[44:24]};
         OP_SPL:  sp_ff <= (spos_ff ? mag_ff[19:0] : 20'd0) + {3'd0, interp(TAB_SPL, mag_ff)};
         OP_STEP: step_ff <= step_rnd[24] ? 24'hFF_FFFF : step_rnd[23:0];
         OP_DMG: begin
            dmg_ff <= dmg_sum[32] ? 32'hFFFF_FFFF : dmg_sum[31:0];
            dw_ff  <= signed'({1'b0, (dmg_sum[32] ? 32'hFFFF_FFFF : dmg_sum[31:0])})
                      - signed'({1'b0, win_ff[1]});
         end
         OP_EXP: e_ff <= interp(TAB_EXP, u_ff);
         OP_AB:  p_ff <= (17'd65536 - e_ff) * ({1'b0, onset_ff} + 17'd65536);
         OP_RG1: rhi_ff <= p_ff[33:17] * REGEN_COEF;
         OP_RG2: regen_ff <= flag_ff ? rtot[58:41] : 18'd0;
         OP_SOC: soc_ff <= vx[22] ? 16'(17'd65536 - hsig) : hsig[15:0];
         OP_HEALTH: health_ff <= soh_c[25:8];
         OP_RATE: begin
            if (!status.dw_big) begin
               rate_ff <= ({16'd0, step_ff} << 8) < RATE_MIN ? RATE_MIN
                          : ({16'd0, step_ff} << 8);
            end
         end
         OP_RATE_FIN: rate_ff <= (quo < RATE_MIN) ? RATE_MIN : quo;
         OP_LIFE: begin
            if (!status.budget_pos) begin
               life_ff <= '0;
            end
         end
         OP_LIFE_FIN: life_ff <= (quo > LIFE_MAX) ? LIFE_MAX[22:0] : quo[22:0];
         OP_OUT: begin
            o_health_ff <= health_ff;
            o_soc_ff    <= soc_ff;
            o_life_ff   <= life_ff;
            o_dmg_ff    <= dmg_ff;
            o_regen_ff  <= regen_ff;
            o_step_ff   <= step_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_health         = o_health_ff;
   assign rsp_charge_level   = o_soc_ff;
   assign rsp_remaining_life = o_life_ff;
   assign rsp_damage_total   = o_dmg_ff;
   assign rsp_regeneration   = o_regen_ff;
   assign rsp_damage_step    = o_step_ff;

endmodule

/* src/bhe_ctrl.sv */
// ----------------------------------------------------------------------------
// bhe_ctrl
// Sequencer: accepts a transaction, steps the datapath, hands off the result.
// ----------------------------------------------------------------------------
module bhe_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  bhe_pkg::status_type status,
   output bhe_pkg::cmd_type    cmd
);
   import bhe_pkg::*;

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_STRESS = 5'd1;
   localparam logic [4:0] ST_UDIV   = 5'd2;
   localparam logic [4:0] ST_SPL    = 5'd3;
   localparam logic [4:0] ST_STEP   = 5'd4;
   localparam logic [4:0] ST_DMG    = 5'd5;
   localparam logic [4:0] ST_EXP    = 5'd6;
   localparam logic [4:0] ST_AB     = 5'd7;
   localparam logic [4:0] ST_RG1    = 5'd8;
   localparam logic [4:0] ST_RG2    = 5'd9;
   localparam logic [4:0] ST_SOC    = 5'd10;
   localparam logic [4:0] ST_HEALTH = 5'd11;
   localparam logic [4:0] ST_RATE   = 5'd12;
   localparam logic [4:0] ST_RWAIT  = 5'd13;
   localparam logic [4:0] ST_RFIN   = 5'd14;
   localparam logic [4:0] ST_LIFE   = 5'd15;
   localparam logic [4:0] ST_LWAIT  = 5'd16;
   localparam logic [4:0] ST_LFIN   = 5'd17;
   localparam logic [4:0] ST_OUT    = 5'd18;

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // advance the sequence
   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_STRESS;
            end
         end
         ST_STRESS: begin cmd.op = OP_STRESS; state_in = ST_UDIV;   end
         ST_UDIV:   begin cmd.op = OP_UDIV;   state_in = ST_SPL;    end
         ST_SPL:    begin cmd.op = OP_SPL;    state_in = ST_STEP;   end
         ST_STEP:   begin cmd.op = OP_STEP;   state_in = ST_DMG;    end
         ST_DMG:    begin cmd.op = OP_DMG;    state_in = ST_EXP;    end
         ST_EXP:    begin cmd.op = OP_EXP;    state_in = ST_AB;     end
         ST_AB:     begin cmd.op = OP_AB;     state_in = ST_RG1;    end
         ST_RG1:    begin cmd.op = OP_RG1;    state_in = ST_RG2;    end
         ST_RG2:    begin cmd.op = OP_RG2;    state_in = ST_SOC;    end
         ST_SOC:    begin cmd.op = OP_SOC;    state_in = ST_HEALTH; end
         ST_HEALTH: begin cmd.op = OP_HEALTH; state_in = ST_RATE;   end
         ST_RATE: begin
            cmd.op   = OP_RATE;
            state_in = status.dw_big ? ST_RWAIT : ST_LIFE;
         end
         ST_RWAIT: begin
            if (status.div_done) begin
               state_in = ST_RFIN;
            end
         end
         ST_RFIN: begin cmd.op = OP_RATE_FIN; state_in = ST_LIFE; end
         ST_LIFE: begin
            cmd.op   = OP_LIFE;
            state_in = status.budget_pos ? ST_LWAIT : ST_OUT;
         end
         ST_LWAIT: begin
            if (status.div_done) begin
               state_in = ST_LFIN;
            end
         end
         ST_LFIN: begin cmd.op = OP_LIFE_FIN; state_in = ST_OUT; end
         ST_OUT: begin
            if (out_free) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not presented after output load");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RWAIT && !status.div_done) |=> (state_ff == ST_RWAIT))
      else $error("left rate division before it finished");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> (cmd.op != OP_OUT))
      else $error("pending result overwritten");

endmodule

/* src/battery_health_estimator.sv */
// ----------------------------------------------------------------------------
// battery_health_estimator
// One transaction per battery cycle in, one health/charge/life result out.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one battery cycle's measurements; the rsp_
//   channel returns health, charge level, remaining life, total damage,
//   regeneration and damage step. Both use valid/stall handshakes.
//   csr_write_enable/csr_write_data set the nominal health (Q1.16, zero
//   means 1.0); write only while no transaction is in flight.
//   After the sequence of datapath steps come the window rate division when
//   the damage window is not flat and the remaining-life division while
//   damage is under budget. Both use the shared one-bit-per-cycle divider.
//   req_stall is high while a transaction is being processed; the next one
//   is taken in the cycle after the previous result loads into the output
//   register.
//   A stalled result holds in the output register; a finished transaction
//   waits in its final step until that register frees up.
//   Reset clears accumulated damage, the damage window and nominal health
//   (back to 1.0), and drops any pending result.
// ----------------------------------------------------------------------------
module battery_health_estimator #(
   parameter int WINDOW_LEN = bhe_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [16:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_temperature,
   input  logic signed [15:0] req_charge_rate,
   input  logic [15:0]        req_rest_duration,
   input  logic [15:0]        req_rest_onset_charge,
   input  logic               req_rest_enable,
   input  logic [15:0]        req_mean_voltage,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [17:0] rsp_health,
   output logic [15:0]        rsp_charge_level,
   output logic [22:0]        rsp_remaining_life,
   output logic [31:0]        rsp_damage_total,
   output logic [17:0]        rsp_regeneration,
   output logic [23:0]        rsp_damage_step
);
   import bhe_pkg::*;

   cmd_type    cmd;
   status_type status;

   bhe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bhe_datapath #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .req_temperature       (req_temperature),
      .req_charge_rate       (req_charge_rate),
      .req_rest_duration     (req_rest_duration),
      .req_rest_onset_charge (req_rest_onset_charge),
      .req_rest_enable       (req_rest_enable),
      .req_mean_voltage      (req_mean_voltage),
      .rsp_health            (rsp_health),
      .rsp_charge_level      (rsp_charge_level),
      .rsp_remaining_life    (rsp_remaining_life),
      .rsp_damage_total      (rsp_damage_total),
      .rsp_regeneration      (rsp_regeneration),
      .rsp_damage_step       (rsp_damage_step)
   );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Battery health estimator testbench
// Drives battery cycle transactions with random idling and stalls, predicts
// health, charge level, remaining life and damage in fixed point, and
// compares every result, all fields at once, against the predicted value.
// ----------------------------------------------------------------------------
module tb;

   localparam int WIN = 8;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic signed [15:0] temperature;
      logic signed [15:0] charge_rate;
      logic [15:0]        rest_duration;
      logic [15:0]        rest_onset_charge;
      logic               rest_enable;
      logic [15:0]        mean_voltage;
   } cycle_type;

   typedef struct packed {
      logic [17:0] health;
      logic [15:0] charge_level;
      logic [22:0] remaining_life;
      logic [31:0] damage_total;
      logic [17:0] regeneration;
      logic [23:0] damage_step;
   } estimate_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [16:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   cycle_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [17:0] rsp_health;
   logic [15:0] rsp_charge_level;
   logic [22:0] rsp_remaining_life;
   logic [31:0] rsp_damage_total;
   logic [17:0] rsp_regeneration;
   logic [23:0] rsp_damage_step;

   // stimulus and prediction stores
   cycle_type    pending_cycles[$];
   estimate_type expected_estimates[$];

   // predictor state
   logic [16:0] nominal = 17'd65536;
   logic [31:0] damage_acc = '0;
   logic [31:0] damage_hist[WIN];

   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int hold_off_cycles = 0;
   int mismatch_count = 0;
   int accepted_count = 0;
   int result_count = 0;
   int quiet_cycles = 0;

   battery_health_estimator uut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_temperature(req_item.temperature), .req_charge_rate(req_item.charge_rate),
      .req_rest_duration(req_item.rest_duration),
      .req_rest_onset_charge(req_item.rest_onset_charge),
      .req_rest_enable(req_item.rest_enable), .req_mean_voltage(req_item.mean_voltage),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_health(rsp_health), .rsp_charge_level(rsp_charge_level),
      .rsp_remaining_life(rsp_remaining_life), .rsp_damage_total(rsp_damage_total),
      .rsp_regeneration(rsp_regeneration), .rsp_damage_step(rsp_damage_step)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // table lookup with linear interpolation over [0, 8], Q16 argument
   function automatic longint table_lookup(input int sel, input longint y);
      longint exp_t[17] = '{65536, 39750, 24109, 14623, 8869, 5380, 3263, 1979, 1200,
                            728, 442, 268, 162, 99, 60, 36, 22};
      longint spl_t[17] = '{45426, 31069, 20530, 13200, 8318, 5170, 3184, 1950, 1189,
                            724, 440, 267, 162, 98, 60, 36, 22};
      longint sig_t[17] = '{32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615,
                            64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500,
                            65514};
      longint t[17];
      longint i;
      longint f;
      if (sel == 0) t = exp_t;
      else if (sel == 1) t = spl_t;
      else t = sig_t;
      i = y >>> 15;
      f = y & 64'h7FFF;
      if (i >= 16) return t[16];
      return (t[i] * (32768 - f) + t[i + 1] * f + 16384) >>> 15;
   endfunction

   // compute one estimate and advance the damage state
   function automatic estimate_type estimate_cycle(input cycle_type c);
      estimate_type e;
      longint s28, mag, sp, step, dmg, u, regen, soh, x, h, soc, dw, rate, budget, life;
      longint nom;
      nom = (nominal == 0) ? 65536 : longint'(nominal);
      s28 = (longint'(c.temperature) - 6400) * 1638 * 16 + longint'(c.charge_rate) * 6554;
      mag = (s28 > 0 ? s28 : -s28) >>> 12;
      sp = (s28 > 0 ? mag : 0) + table_lookup(1, mag);
      step = (sp * 12884902 + (64'd1 << 23)) >>> 24;
      if (step > 64'hFFFFFF) step = 64'hFFFFFF;
      dmg = longint'(damage_acc) + step;
      if (dmg > 64'hFFFFFFFF) dmg = 64'hFFFFFFFF;
      u = (longint'(c.rest_duration) << 8) / 12;
      // shift in two steps; the rounding matches one 41-bit shift
      regen = 65536 - table_lookup(0, u);
      regen = (((regen * (65536 + longint'(c.rest_onset_charge))) * 64424509) >>> 20);
      regen = (regen + (64'd1 << 20)) >>> 21;
      if (!c.rest_enable) regen = 0;
      soh = (nom << 8) - dmg + regen;
      if (soh < -33554432) soh = -33554432;
      if (soh > 33554431) soh = 33554431;
      e.health = 18'(((soh + 33554432) >>> 8) - 131072);
      x = longint'(c.mean_voltage) * 64 - 943718;
      h = table_lookup(2, x >= 0 ? x : -x);
      soc = x >= 0 ? h : 65536 - h;
      for (int i = 0; i < WIN - 1; i++) damage_hist[i] = damage_hist[i + 1];
      damage_hist[WIN - 1] = 32'(dmg);
      dw = longint'(damage_hist[WIN - 1]) - longint'(damage_hist[0]);
      rate = (dw > 167) ? (dw << 8) / WIN : step << 8;
      if (rate < 4295) rate = 4295;
      budget = 5033165 - dmg;
      life = (budget > 0) ? (budget << 12) / rate : 0;
      if (life > 4800000) life = 4800000;
      damage_acc = 32'(dmg);
      e.charge_level = 16'(soc);
      e.remaining_life = 23'(life);
      e.damage_total = 32'(dmg);
      e.regeneration = 18'(regen);
      e.damage_step = 24'(step);
      return e;
   endfunction

   function automatic cycle_type random_cycle();
      cycle_type c;
      c.temperature = 16'($urandom);
      c.charge_rate = 16'($urandom);
      c.rest_duration = 16'($urandom);
      c.rest_onset_charge = 16'($urandom);
      c.rest_enable = 1'($urandom);
      c.mean_voltage = 16'($urandom);
      // most cycles sit near realistic operating points
      if ($urandom_range(0, 3) != 0) begin
         c.temperature = 16'($signed($urandom_range(0, 16000)) - 1000);
         c.charge_rate = 16'($signed($urandom_range(0, 20000)) - 4000);
         c.mean_voltage = 16'($urandom_range(10000, 20000));
      end
      return c;
   endfunction

   // driver: offer the next queued transaction, hold while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) accepted_count <= accepted_count + 1;
         if (pending_cycles.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_item <= pending_cycles.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // predict on acceptance
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         expected_estimates.push_back(estimate_cycle(req_item));
   end

   // receiver stall, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   // monitor: compare each result with the oldest prediction
   always @(posedge clock) begin
      estimate_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_health, rsp_charge_level, rsp_remaining_life, rsp_damage_total,
                rsp_regeneration, rsp_damage_step};
         result_count <= result_count + 1;
         if (expected_estimates.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) $display("unexpected result %p", got);
         end else begin
            want = expected_estimates.pop_front();
            if (got !== want) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   // watchdog on cycles without any accepted transaction or taken result
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else if (pending_cycles.size() > 0 || expected_estimates.size() > 0
               || req_valid) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic drain();
      while (pending_cycles.size() > 0 || req_valid || expected_estimates.size() > 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_nominal(input logic [16:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      nominal = value;
   endtask

   initial begin
      cycle_type c;
      logic [16:0] settings[4];
      settings = '{17'd0, 17'd131071, 17'd40000, 17'd65536};
      for (int i = 0; i < WIN; i++) damage_hist[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, rest flag both ways, table ends
      for (int k = 0; k < 20; k++) begin
         c = '0;
         c.temperature = (k % 4 == 0) ? 16'sh7FFF : (k % 4 == 1) ? 16'sh8000 : 16'sd6400;
         c.charge_rate = (k % 3 == 0) ? 16'sh7FFF : (k % 3 == 1) ? 16'sh8000 : 16'sd0;
         c.rest_duration = (k % 2) ? 16'hFFFF : 16'd0;
         c.rest_onset_charge = (k % 5 < 2) ? 16'hFFFF : 16'd0;
         c.rest_enable = k[0] ^ k[2];
         c.mean_voltage = (k % 3 == 0) ? 16'hFFFF : (k % 3 == 1) ? 16'd0 : 16'd14746;
         pending_cycles.push_back(c);
      end
      drain();

      // random phases under changing nominal health and idling
      for (int p = 0; p < 4; p++) begin
         write_nominal(settings[p]);
         sender_idle_pct = (p == 0) ? 13 : (p == 1) ? 66 : 0;
         receiver_idle_pct = (p == 0) ? 66 : (p == 1) ? 13 : 0;
         if (p == 3) hold_off_cycles = 600;
         for (int k = 0; k < 110; k++) pending_cycles.push_back(random_cycle());
         drain();
      end

      $display("covered %0d cycles with %0d results over four nominal health settings",
               accepted_count, result_count);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
